// ===== rtl/core/kic_pkg.sv =====
// Shared definitions for the keypad integer calculator.
// Key codes, operator and command codes, engine states and the control structs
// passed between the top level and the arithmetic engine. No dependencies.
package kic_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;
  localparam int unsigned RESULT_WIDTH      = 32;

  localparam logic [7:0] KEY_0   = 8'h30;
  localparam logic [7:0] KEY_9   = 8'h39;
  localparam logic [7:0] KEY_ADD = 8'h2B;
  localparam logic [7:0] KEY_SUB = 8'h2D;
  localparam logic [7:0] KEY_MUL = 8'h78;
  localparam logic [7:0] KEY_DIV = 8'h2F;
  localparam logic [7:0] KEY_EQ  = 8'h23;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic {
    CMD_DIGIT  = 1'b0,
    CMD_EQUALS = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    E_IDLE     = 3'd0,
    E_DIGIT    = 3'd1,
    E_ADDSUB   = 3'd2,
    E_MUL      = 3'd3,
    E_DIV_PREP = 3'd4,
    E_DIV      = 3'd5,
    E_DIV_FIX  = 3'd6,
    E_DONE     = 3'd7
  } eng_state_e;

  typedef struct packed {
    logic       start;
    cmd_e       kind;
    logic       sel_second;
    logic [3:0] digit;
    op_e        op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic err;
  } eng_status_t;

endpackage

// ===== rtl/core/keypad_integer_calculator_top.sv =====
// Top level of the keypad integer calculator: key decoding, entry phase and result register.
// Instantiates kic_engine and depends on kic_pkg.
//
// Usage: one ASCII key code is taken per transaction on the input channel
// (in_valid_i, in_ready_o, key_code_i). Digits build the current operand in
// decimal, the keys '+', '-', 'x' and '/' select the operation and move entry
// to the second operand, and '#' starts the calculation. A result transaction
// (result_value_o, divide_error_o) is issued on the output channel only when an
// operator has been given; the key after '#' is always discarded.
// Timing: digits, adds, subtracts, multiplies and divides hold the input
// channel while the engine works, one operand bit per cycle through its
// shift registers; a divide first prepares the operand magnitudes and
// finally fixes the quotient sign, and a zero divisor skips the shift loop.
// Operator keys, discarded keys and '#' with no operator do not start the engine.
// The result is loaded into the output register once the engine has finished.
// The output register holds one result; while it is full and stalled the
// engine keeps its finished result and in_ready_o stays low. Reset clears
// both operands, the operator, the entry phase and the output valid flag.
module keypad_integer_calculator_top #(
  parameter int unsigned OperandWidth = kic_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         key_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               divide_error_o
);

  localparam int unsigned W = OperandWidth;

  kic_pkg::op_e         op_q, op_d;
  logic                 second_q, second_d;
  logic                 skip_q, skip_d;
  logic                 out_valid_q, out_valid_d;
  logic [31:0]          result_q;
  logic                 err_out_q;

  kic_pkg::cmd_t        cmd;
  kic_pkg::eng_status_t status;
  logic [W-1:0]         eng_value;
  logic [31:0]          res32;
  logic                 accept, is_digit, is_oper, is_eq, load;
  logic [7:0]           key_off;

  kic_engine #(
    .OperandWidth(OperandWidth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .res_ready_i(load),
    .status_o   (status),
    .res_value_o(eng_value)
  );

  for (genvar k = 0; k < 32; k++) begin : g_ext
    if (k < W) begin : g_bit
      assign res32[k] = eng_value[k];
    end else begin : g_sign
      assign res32[k] = eng_value[W-1];
    end
  end

  always_comb begin
    in_ready_o = ~status.busy;
    accept     = in_valid_i & in_ready_o;
    key_off    = key_code_i - kic_pkg::KEY_0;
    is_digit   = (key_code_i >= kic_pkg::KEY_0) && (key_code_i <= kic_pkg::KEY_9);
    is_eq      = (key_code_i == kic_pkg::KEY_EQ);
    is_oper    = 1'b1;
    op_d       = op_q;
    case (key_code_i)
      kic_pkg::KEY_ADD: op_d = kic_pkg::OP_ADD;
      kic_pkg::KEY_SUB: op_d = kic_pkg::OP_SUB;
      kic_pkg::KEY_MUL: op_d = kic_pkg::OP_MUL;
      kic_pkg::KEY_DIV: op_d = kic_pkg::OP_DIV;
      default:          is_oper = 1'b0;
    endcase

    cmd.start      = accept & ~skip_q & (is_digit | is_eq);
    cmd.kind       = is_eq ? kic_pkg::CMD_EQUALS : kic_pkg::CMD_DIGIT;
    cmd.sel_second = second_q;
    cmd.digit      = key_off[3:0];
    cmd.op         = op_q;

    second_d = second_q;
    skip_d   = skip_q;
    if (accept) begin
      if (skip_q) begin
        skip_d = 1'b0;
        op_d   = op_q;
      end else if (is_oper) begin
        second_d = 1'b1;
      end else if (is_eq) begin
        second_d = 1'b0;
        skip_d   = 1'b1;
      end
    end else begin
      op_d = op_q;
    end
    if (accept && !skip_q && !is_oper) begin
      op_d = op_q;
    end

    load        = status.res_valid & (~out_valid_q | out_ready_i);
    out_valid_d = load | (out_valid_q & ~out_ready_i);

    out_valid_o    = out_valid_q;
    result_value_o = result_q;
    divide_error_o = err_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= kic_pkg::OP_NONE;
      second_q    <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      op_q        <= op_d;
      second_q    <= second_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q  <= res32;
      err_out_q <= status.err;
    end
  end

endmodule

// ===== rtl/core/kic_engine.sv =====
// Serial arithmetic engine of the keypad integer calculator: holds both operands,
// folds decimal digits in one bit per cycle and runs add, subtract, multiply and divide.
// Depends on kic_pkg.
module kic_engine #(
  parameter int unsigned OperandWidth = kic_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kic_pkg::cmd_t            cmd_i,
  input  logic                     res_ready_i,
  output kic_pkg::eng_status_t     status_o,
  output logic [OperandWidth-1:0]  res_value_o
);

  localparam int unsigned W        = OperandWidth;
  localparam int unsigned CntWidth = $clog2(OperandWidth);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(OperandWidth - 1);

  kic_pkg::eng_state_e state_q, state_d;
  kic_pkg::op_e        op_q;

  logic [W-1:0]        a_q, b_q, acc_q, rem_q;
  logic [CntWidth-1:0] cnt_q;
  logic [1:0]          carry_q;
  logic [2:0]          hist_q;
  logic [3:0]          dig_q;
  logic                sel_q, neg_q, err_q;

  logic                cnt_last, b_zero, b_eff;
  logic [W-1:0]        x_cur, x_next, mul_next, a_neg, b_neg, acc_neg;
  logic [2:0]          dsum;
  logic [1:0]          asum;
  logic [W:0]          rem_shift, rem_diff;

  always_comb begin
    cnt_last  = (cnt_q == CntLast);
    b_zero    = (b_q == '0);
    x_cur     = sel_q ? b_q : a_q;
    dsum      = {2'b00, hist_q[0]} + {2'b00, hist_q[2]} + {2'b00, dig_q[0]}
              + {1'b0, carry_q};
    x_next    = {dsum[0], x_cur[W-1:1]};
    b_eff     = b_q[0] ^ (op_q == kic_pkg::OP_SUB);
    asum      = {1'b0, a_q[0]} + {1'b0, b_eff} + {1'b0, carry_q[0]};
    mul_next  = {acc_q[W-2:0], 1'b0} + (b_q[W-1] ? a_q : '0);
    a_neg     = ~a_q + W'(1);
    b_neg     = ~b_q + W'(1);
    acc_neg   = ~acc_q + W'(1);
    rem_shift = {rem_q, a_q[W-1]};
    rem_diff  = rem_shift - {1'b0, b_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kic_pkg::E_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.kind == kic_pkg::CMD_DIGIT) begin
            state_d = kic_pkg::E_DIGIT;
          end else begin
            case (cmd_i.op)
              kic_pkg::OP_ADD: state_d = kic_pkg::E_ADDSUB;
              kic_pkg::OP_SUB: state_d = kic_pkg::E_ADDSUB;
              kic_pkg::OP_MUL: state_d = kic_pkg::E_MUL;
              kic_pkg::OP_DIV: state_d = kic_pkg::E_DIV_PREP;
              default:         state_d = kic_pkg::E_IDLE;
            endcase
          end
        end
      end
      kic_pkg::E_DIGIT:    if (cnt_last) state_d = kic_pkg::E_IDLE;
      kic_pkg::E_ADDSUB:   if (cnt_last) state_d = kic_pkg::E_DONE;
      kic_pkg::E_MUL:      if (cnt_last) state_d = kic_pkg::E_DONE;
      kic_pkg::E_DIV_PREP: state_d = b_zero ? kic_pkg::E_DONE : kic_pkg::E_DIV;
      kic_pkg::E_DIV:      if (cnt_last) state_d = kic_pkg::E_DIV_FIX;
      kic_pkg::E_DIV_FIX:  state_d = kic_pkg::E_DONE;
      kic_pkg::E_DONE:     if (res_ready_i) state_d = kic_pkg::E_IDLE;
      default:             state_d = kic_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    status_o.busy      = (state_q != kic_pkg::E_IDLE);
    status_o.res_valid = (state_q == kic_pkg::E_DONE);
    status_o.err       = err_q;
    res_value_o        = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kic_pkg::E_IDLE;
      op_q    <= kic_pkg::OP_NONE;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      carry_q <= '0;
      hist_q  <= '0;
      dig_q   <= '0;
      sel_q   <= 1'b0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        kic_pkg::E_IDLE: begin
          cnt_q  <= '0;
          hist_q <= '0;
          if (cmd_i.start) begin
            op_q    <= cmd_i.op;
            sel_q   <= cmd_i.sel_second;
            dig_q   <= cmd_i.digit;
            carry_q <= {1'b0, (cmd_i.kind == kic_pkg::CMD_EQUALS) &&
                              (cmd_i.op == kic_pkg::OP_SUB)};
            acc_q   <= '0;
            rem_q   <= '0;
            err_q   <= 1'b0;
            if (cmd_i.kind == kic_pkg::CMD_EQUALS && cmd_i.op == kic_pkg::OP_NONE) begin
              a_q <= '0;
              b_q <= '0;
            end
          end
        end
        kic_pkg::E_DIGIT: begin
          if (sel_q) begin
            b_q <= x_next;
          end else begin
            a_q <= x_next;
          end
          hist_q  <= {hist_q[1:0], x_cur[0]};
          dig_q   <= {1'b0, dig_q[3:1]};
          carry_q <= dsum[2:1];
          cnt_q   <= cnt_q + CntWidth'(1);
        end
        kic_pkg::E_ADDSUB: begin
          // Both operands shift out completely, which also clears them.
          acc_q   <= {asum[0], acc_q[W-1:1]};
          a_q     <= {1'b0, a_q[W-1:1]};
          b_q     <= {1'b0, b_q[W-1:1]};
          carry_q <= {1'b0, asum[1]};
          cnt_q   <= cnt_q + CntWidth'(1);
        end
        kic_pkg::E_MUL: begin
          acc_q <= mul_next;
          b_q   <= {b_q[W-2:0], 1'b0};
          if (cnt_last) begin
            a_q <= '0;
          end
          cnt_q <= cnt_q + CntWidth'(1);
        end
        kic_pkg::E_DIV_PREP: begin
          neg_q <= a_q[W-1] ^ b_q[W-1];
          err_q <= b_zero;
          cnt_q <= '0;
          if (b_zero) begin
            a_q <= '0;
            b_q <= '0;
          end else begin
            a_q <= a_q[W-1] ? a_neg : a_q;
            b_q <= b_q[W-1] ? b_neg : b_q;
          end
        end
        kic_pkg::E_DIV: begin
          rem_q <= rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
          acc_q <= {acc_q[W-2:0], ~rem_diff[W]};
          a_q   <= {a_q[W-2:0], 1'b0};
          if (cnt_last) begin
            b_q <= '0;
          end
          cnt_q <= cnt_q + CntWidth'(1);
        end
        kic_pkg::E_DIV_FIX: begin
          if (neg_q) begin
            acc_q <= acc_neg;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
